/* src/kvt_pkg.sv */
package kvt_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int CMD_W         = 2;
   localparam int CAP_W         = 6;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      OP_GET,
      OP_INSERT,
      OP_REMOVE,
      OP_NOP
   } kvt_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_ENCODE,
      ST_EXEC,
      ST_READ,
      ST_DONE
   } kvt_state_type;

   typedef struct packed {
      kvt_op_type                op;
      logic signed [KEY_W-1:0]   key;
      logic        [VALUE_W-1:0] value;
   } kvt_item_type;

endpackage

/* src/kvt_if.sv */
interface kvt_req_if;
   import kvt_pkg::*;

   logic                         valid;
   logic                         ready;
   logic        [CMD_W-1:0]      command;
   logic signed [KEY_W-1:0]      key;
   logic        [VALUE_W-1:0]    value;

   modport source (output valid, output command, output key, output value, input ready);
   modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
   import kvt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_W-1:0]    read_value;
   logic                  hit;

   modport source (output valid, output read_value, output hit, input ready);
   modport sink   (input valid, input read_value, input hit, output ready);
endinterface

/* src/kvt_ram.sv */
module kvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/kvt_front.sv */
module kvt_front (
   input  logic                  clock,
   input  logic                  reset,
   kvt_req_if.sink               req,
   output logic                  q_valid,
   input  logic                  q_ready,
   output kvt_pkg::kvt_item_type q_item
);
   import kvt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   kvt_item_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   kvt_item_type           item_in;
   logic                   push, pop;

   // command decode into an internal opcode
   always_comb begin
      item_in.key   = req.key;
      item_in.value = req.value;
      unique case (req.command)
         CMD_GET:    item_in.op = OP_GET;
         CMD_INSERT: item_in.op = OP_INSERT;
         CMD_REMOVE: item_in.op = OP_REMOVE;
         default:    item_in.op = OP_NOP;
      endcase
   end

   assign req.ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* src/kvt_back.sv */
module kvt_back #(
   parameter int DEPTH = kvt_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [kvt_pkg::CAP_W-1:0]      cap,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  kvt_pkg::kvt_item_type          q_item,
   kvt_rsp_if.source                      rsp,
   output logic [$clog2(DEPTH+1)-1:0]     entry_count
);
   import kvt_pkg::*;

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   kvt_state_type        state_ff, state_in;
   kvt_item_type         item_ff;
   logic [KEY_W-1:0]     keys_ff [DEPTH];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DEPTH-1:0]     match_ff, match_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 hit_ff, hit_in;
   logic [VALUE_W-1:0]   rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_hit_ff;

   logic [SLOT_W-1:0]    last_slot;
   logic [SLOT_W-1:0]    tail_slot;
   logic                 room;
   logic                 out_free;

   logic                 pop;
   logic                 key_we;
   logic [SLOT_W-1:0]    key_waddr;
   logic [KEY_W-1:0]     key_wdata;
   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_waddr;
   logic [VALUE_W-1:0]   ram_wdata;
   logic [SLOT_W-1:0]    ram_raddr;
   logic [VALUE_W-1:0]   ram_rdata;
   logic                 count_inc, count_dec;
   logic                 rd_clear, rd_load;
   logic                 rsp_load;

   assign last_slot = SLOT_W'(count_ff - 1'b1);
   assign tail_slot = SLOT_W'(count_ff);
   assign room      = (count_ff < CNT_W'(DEPTH)) && (CMP_W'(count_ff) < CMP_W'(cap));
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // parallel compare against every live entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (keys_ff[i] == item_ff.key) && (CNT_W'(i) < count_ff);
      end
   end

   // lowest matching slot wins
   always_comb begin
      slot_in = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            slot_in = SLOT_W'(i);
         end
      end
      hit_in = |match_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_MATCH;
         ST_MATCH:  state_in = ST_ENCODE;
         ST_ENCODE: state_in = ST_EXEC;
         ST_EXEC: begin
            if (hit_ff && (item_ff.op == OP_GET || item_ff.op == OP_REMOVE)) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ:   state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      key_we    = 1'b0;
      key_waddr = slot_ff;
      key_wdata = item_ff.key;
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = item_ff.value;
      ram_raddr = slot_ff;
      count_inc = 1'b0;
      count_dec = 1'b0;
      rd_clear  = 1'b0;
      rd_load   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   pop = q_valid;
         ST_MATCH:  ;
         ST_ENCODE: ;
         ST_EXEC: begin
            rd_clear = 1'b1;
            case (item_ff.op)
               OP_INSERT: begin
                  if (hit_ff) begin
                     ram_we = 1'b1;
                  end else if (room) begin
                     key_we    = 1'b1;
                     key_waddr = tail_slot;
                     ram_we    = 1'b1;
                     ram_waddr = tail_slot;
                     count_inc = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff) begin
                     key_we    = 1'b1;
                     key_wdata = keys_ff[last_slot];
                     ram_raddr = last_slot;
                  end
               end
               default: ;
            endcase
         end
         ST_READ: begin
            if (item_ff.op == OP_REMOVE) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               count_dec = 1'b1;
            end else begin
               rd_load = 1'b1;
            end
         end
         ST_DONE:   rsp_load = out_free;
         default:   ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (count_dec) begin
         count_in = count_ff - 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_MATCH) begin
         match_ff <= match_in;
      end
      if (state_ff == ST_ENCODE) begin
         slot_ff <= slot_in;
         hit_ff  <= hit_in;
      end
      if (key_we) begin
         keys_ff[key_waddr] <= key_wdata;
      end
      if (rd_clear) begin
         rd_ff <= '0;
      end else if (rd_load) begin
         rd_ff <= ram_rdata;
      end
      if (rsp_load) begin
         rsp_value_ff <= rd_ff;
         rsp_hit_ff   <= hit_ff;
      end
   end

   kvt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign q_ready        = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = rsp_value_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign entry_count    = count_ff;

endmodule

/* src/small_key_value_table.sv */
// Small unsorted key-value table (get, insert/update, remove) holding up to DEPTH entries,
// further limited by the 6-bit capacity register written through csr_we/csr_wdata.
// A two-entry input queue takes transactions while the execution side is busy. Each
// transaction then passes through the execution side in these steps (the read is skipped
// when no value read is needed): fetch, parallel key compare across all entries held in
// flops, priority encode, update, value-store read, result. The value store is a RAM with
// one write port and a registered read port, which is why gets and removes that hit need
// the read step. A result waiting at rsp holds the execution side in its result step; the
// queue keeps accepting until both of its entries are taken. No clearing pass after reset.
module small_key_value_table #(
   parameter int DEPTH = kvt_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   kvt_req_if.sink                    req,
   kvt_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [kvt_pkg::CAP_W-1:0]  csr_wdata
);
   import kvt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CAP_W-1:0]  cap_ff;
   logic              q_valid;
   logic              q_ready;
   kvt_item_type      q_item;
   logic [CNT_W-1:0]  entry_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   kvt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   kvt_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cap         (cap_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .rsp         (rsp),
      .entry_count (entry_count)
   );

`ifndef SYNTHESIS
   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.hit || rsp.read_value == '0))
      else $error("response without hit carries a non-zero value");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> !q_ready)
      else $error("execution side took a second transaction while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count <= CNT_W'(DEPTH))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(entry_count) |-> $past(q_ready) == 1'b0)
      else $error("entry count changed while idle");
`endif

endmodule
